// File: design/tlfr_pkg.sv
package tlfr_pkg;

	// header layout
	localparam int HEADER_BYTES = 4;
	localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

	// field widths
	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int ERR_W   = 3;
	localparam int COUNT_W = 32;

	// commands
	localparam logic [CMD_W-1:0] CMD_DATA    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_EOS     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_XPORT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

	// latched error codes
	localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
	localparam logic [ERR_W-1:0] ERR_TYPE   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_LENGTH = 3'd2;
	localparam logic [ERR_W-1:0] ERR_TRUNC  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_XPORT  = 3'd4;

	// header byte positions
	localparam logic [HDR_IDX_W-1:0] IDX_TYPE   = HDR_IDX_W'(0);
	localparam logic [HDR_IDX_W-1:0] IDX_LEN_LO = HDR_IDX_W'(1);
	localparam logic [HDR_IDX_W-1:0] IDX_LEN_HI = HDR_IDX_W'(2);
	localparam logic [HDR_IDX_W-1:0] IDX_AUX    = HDR_IDX_W'(3);

	// frame types
	localparam logic [BYTE_W-1:0] TYPE_A = 8'hA0;
	localparam logic [BYTE_W-1:0] TYPE_B = 8'hB0;

	localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 16'd4096;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

	typedef struct packed {
		logic               header_valid;
		logic               frame_channel;
		logic [LEN_W-1:0]   frame_payload_length;
		logic [BYTE_W-1:0]  header_aux_byte;
		logic               payload_valid;
		logic [BYTE_W-1:0]  payload_out;
		logic               frame_end;
		logic [ERR_W-1:0]   error_code;
		logic               fenced;
		logic [COUNT_W-1:0] frames_delivered;
	} result_t;

endpackage

// File: design/tlfr_byte_if.sv
interface tlfr_byte_if;
	logic                        valid;
	logic                        ready;
	logic [tlfr_pkg::CMD_W-1:0]  command;
	logic [tlfr_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink (input valid, input command, input data_byte, output ready);
endinterface

// File: design/tlfr_result_if.sv
interface tlfr_result_if;
	logic                         valid;
	logic                         ready;
	logic                         header_valid;
	logic                         frame_channel;
	logic [tlfr_pkg::LEN_W-1:0]   frame_payload_length;
	logic [tlfr_pkg::BYTE_W-1:0]  header_aux_byte;
	logic                         payload_valid;
	logic [tlfr_pkg::BYTE_W-1:0]  payload_out;
	logic                         frame_end;
	logic [tlfr_pkg::ERR_W-1:0]   error_code;
	logic                         fenced;
	logic [tlfr_pkg::COUNT_W-1:0] frames_delivered;

	modport source (
		output valid, output header_valid, output frame_channel,
		output frame_payload_length, output header_aux_byte, output payload_valid,
		output payload_out, output frame_end, output error_code, output fenced,
		output frames_delivered, input ready
	);
	modport sink (
		input valid, input header_valid, input frame_channel,
		input frame_payload_length, input header_aux_byte, input payload_valid,
		input payload_out, input frame_end, input error_code, input fenced,
		input frames_delivered, output ready
	);
endinterface

// File: design/tlfr_engine.sv
module tlfr_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [tlfr_pkg::CMD_W-1:0]    command,
	input  logic [tlfr_pkg::BYTE_W-1:0]   data_byte,
	input  logic [tlfr_pkg::LEN_W-1:0]    max_len,
	output logic                          has_result,
	output tlfr_pkg::result_t             res
);

	logic [tlfr_pkg::HDR_IDX_W-1:0] idx_q, idx_d;
	logic                           in_pay_q, in_pay_d;
	logic                           type_q, type_d;
	logic                           type_ok_q, type_ok_d;
	logic [tlfr_pkg::LEN_W-1:0]     len_q, len_d;
	logic [tlfr_pkg::LEN_W-1:0]     remain_q, remain_d;
	logic                           fence_q, fence_d;
	logic [tlfr_pkg::ERR_W-1:0]     err_q, err_d;
	logic [tlfr_pkg::COUNT_W-1:0]   count_q, count_d;
	logic                           fail_req;
	logic [tlfr_pkg::ERR_W-1:0]     fail_code;
	logic                           last;

	// decode one item against the framing state
	always_comb begin
		idx_d      = idx_q;
		in_pay_d   = in_pay_q;
		type_d     = type_q;
		type_ok_d  = type_ok_q;
		len_d      = len_q;
		remain_d   = remain_q;
		fence_d    = fence_q;
		err_d      = err_q;
		count_d    = count_q;
		fail_req   = 1'b0;
		fail_code  = tlfr_pkg::ERR_NONE;
		has_result = 1'b0;
		last       = 1'b0;
		res        = '0;

		case (command)
			tlfr_pkg::CMD_DATA: begin
				if (!fence_q) begin
					if (in_pay_q) begin
						// pass one payload byte, close the frame on the last
						remain_d = remain_q - 16'd1;
						last     = (remain_d == '0);
						if (last) begin
							in_pay_d = 1'b0;
							if (count_q != tlfr_pkg::COUNT_MAX) begin
								count_d = count_q + 32'd1;
							end
						end
						has_result        = 1'b1;
						res.payload_valid = 1'b1;
						res.frame_channel = type_q;
						res.payload_out   = data_byte;
						res.frame_end     = last;
					end else begin
						case (idx_q)
							tlfr_pkg::IDX_TYPE: begin
								type_ok_d = (data_byte == tlfr_pkg::TYPE_A) ||
									(data_byte == tlfr_pkg::TYPE_B);
								type_d    = (data_byte == tlfr_pkg::TYPE_B);
								idx_d     = tlfr_pkg::IDX_LEN_LO;
							end
							tlfr_pkg::IDX_LEN_LO: begin
								len_d = {8'h00, data_byte};
								idx_d = tlfr_pkg::IDX_LEN_HI;
							end
							tlfr_pkg::IDX_LEN_HI: begin
								len_d = {data_byte, len_q[7:0]};
								idx_d = tlfr_pkg::IDX_AUX;
							end
							default: begin
								// check the completed header: type before length
								idx_d      = tlfr_pkg::IDX_TYPE;
								has_result = 1'b1;
								if (!type_ok_q) begin
									fail_req  = 1'b1;
									fail_code = tlfr_pkg::ERR_TYPE;
								end else if (len_q == '0 || len_q > max_len) begin
									fail_req  = 1'b1;
									fail_code = tlfr_pkg::ERR_LENGTH;
								end else begin
									in_pay_d                 = 1'b1;
									remain_d                 = len_q;
									res.header_valid         = 1'b1;
									res.frame_channel        = type_q;
									res.frame_payload_length = len_q;
									res.header_aux_byte      = data_byte;
								end
							end
						endcase
					end
				end
			end
			tlfr_pkg::CMD_EOS: begin
				has_result = 1'b1;
				if (!fence_q && (idx_q != tlfr_pkg::IDX_TYPE || in_pay_q)) begin
					fail_req  = 1'b1;
					fail_code = tlfr_pkg::ERR_TRUNC;
				end
			end
			tlfr_pkg::CMD_XPORT: begin
				has_result = 1'b1;
				if (!fence_q) begin
					fail_req  = 1'b1;
					fail_code = tlfr_pkg::ERR_XPORT;
				end
			end
			tlfr_pkg::CMD_CANCEL: begin
				has_result = 1'b1;
				fence_d    = 1'b1;
				idx_d      = tlfr_pkg::IDX_TYPE;
				in_pay_d   = 1'b0;
				remain_d   = '0;
			end
			tlfr_pkg::CMD_RESTART: begin
				has_result = 1'b1;
				fence_d    = 1'b0;
				err_d      = tlfr_pkg::ERR_NONE;
				idx_d      = tlfr_pkg::IDX_TYPE;
				in_pay_d   = 1'b0;
				remain_d   = '0;
			end
			default: begin
			end
		endcase

		// keep only the first error, always fence
		if (fail_req) begin
			if (err_q == tlfr_pkg::ERR_NONE) begin
				err_d = fail_code;
			end
			fence_d = 1'b1;
		end

		// status reflects the state after this item
		res.error_code       = err_d;
		res.fenced           = fence_d;
		res.frames_delivered = count_d;
	end

	// advance the framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= tlfr_pkg::IDX_TYPE;
			in_pay_q  <= 1'b0;
			type_q    <= 1'b0;
			type_ok_q <= 1'b0;
			len_q     <= '0;
			remain_q  <= '0;
			fence_q   <= 1'b1;
			err_q     <= tlfr_pkg::ERR_NONE;
			count_q   <= '0;
		end else if (step) begin
			idx_q     <= idx_d;
			in_pay_q  <= in_pay_d;
			type_q    <= type_d;
			type_ok_q <= type_ok_d;
			len_q     <= len_d;
			remain_q  <= remain_d;
			fence_q   <= fence_d;
			err_q     <= err_d;
			count_q   <= count_d;
		end
	end

endmodule

// File: design/typed_length_frame_router_unit.sv
// Channel   Role    Payload
// stream    sink    command, data_byte
// result    source  header/payload fields, error_code, fenced, frames_delivered
// cfg       write   cfg_we, cfg_wdata -> max_payload_length
//
// One item per cycle while the result is taken; a transfer passes the input
// register, then the result register after the framing decode.
// Items that give no result (header bytes before the aux byte, fenced data) retire silently.
// Reset comes up fenced, no error, max_payload_length 4096, count zero.
// A stalled result holds its register; the input register still drains into
// it as soon as the result is taken, so ready drops only on a full stall.
module typed_length_frame_router_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	tlfr_byte_if.sink                   stream,
	tlfr_result_if.source               result,
	input  logic                        cfg_we,
	input  logic [tlfr_pkg::LEN_W-1:0]  cfg_wdata
);

	logic [tlfr_pkg::LEN_W-1:0]  max_len_q;
	logic                        valid_s1;
	logic [tlfr_pkg::CMD_W-1:0]  command_s1;
	logic [tlfr_pkg::BYTE_W-1:0] data_s1;
	logic                        valid_s2;
	tlfr_pkg::result_t           res_s2;
	tlfr_pkg::result_t           res_d;
	logic                        has_result;
	logic                        out_free;
	logic                        step;

	// hold the length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= tlfr_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// handshake: stage 1 drains whenever the result register can take it
	assign out_free     = !valid_s2 || result.ready;
	assign step         = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			command_s1 <= stream.command;
			data_s1    <= stream.data_byte;
		end
	end

	tlfr_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.command    (command_s1),
		.data_byte  (data_s1),
		.max_len    (max_len_q),
		.has_result (has_result),
		.res        (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid                = valid_s2;
	assign result.header_valid         = res_s2.header_valid;
	assign result.frame_channel        = res_s2.frame_channel;
	assign result.frame_payload_length = res_s2.frame_payload_length;
	assign result.header_aux_byte      = res_s2.header_aux_byte;
	assign result.payload_valid        = res_s2.payload_valid;
	assign result.payload_out          = res_s2.payload_out;
	assign result.frame_end            = res_s2.frame_end;
	assign result.error_code           = res_s2.error_code;
	assign result.fenced               = res_s2.fenced;
	assign result.frames_delivered     = res_s2.frames_delivered;

	// a pending item survives a result stall
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("input stage lost an item under stall");

	// a latched error always comes with the fence up
	a_err_fenced: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.error_code != tlfr_pkg::ERR_NONE |-> res_s2.fenced)
		else $error("error reported without fence");

	// header and payload never share a result
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({res_s2.header_valid, res_s2.payload_valid}))
		else $error("header and payload in one result");

	// frame end only on a payload byte
	a_end_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_end |-> res_s2.payload_valid)
		else $error("frame end without payload byte");

endmodule
